// ===== rtl/core/propeller_thrust_torque_defines.svh =====
// assertion macros shared by the propeller thrust and torque rtl
`ifndef PROPELLER_THRUST_TORQUE_DEFINES_SVH
`define PROPELLER_THRUST_TORQUE_DEFINES_SVH

// same-cycle implication on clk, quiet while rst is high
`define PTT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication on clk, quiet while rst is high
`define PTT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ptt_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and helpers for the propeller thrust and torque pipeline
package ptt_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 26;
  localparam int DIAM_W     = 20;
  localparam int JZ_W       = 20;
  localparam int COEF_W     = 26;
  localparam int RHO_W      = 18;

  localparam logic [DIAM_W-1:0] DIAM_RST = 20'd65536;
  localparam logic [JZ_W-1:0]   JZ_RST   = 20'd32768;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIAMETER       = 4'd0,
    REG_ZERO_THRUST    = 4'd1,
    REG_STATIC_THRUST  = 4'd2,
    REG_PROFILE_TORQUE = 4'd3
  } ptt_reg_t;

  // fixed-point constants: 1/(2*pi) in Q0.32, 2*pi in Q3.29
  localparam logic [31:0] INV_TWO_PI_Q32 = 32'd683565276;
  localparam logic [31:0] TWO_PI_Q29     = 32'd3373259426;
  localparam logic [31:0] J_CAP          = 32'h8000_0000;
  localparam logic [31:0] J_POS_MAX      = 32'h7fff_ffff;

  // multiplier: 64x64 split into four 32x32 partial products
  localparam int MUL_W  = 64;
  localparam int MUL_HW = MUL_W / 2;

  // advance ratio divider: numerator 63 bits times 8, divisor 51 bits
  localparam int JNUM_W     = 63;
  localparam int JDEN_W     = 51;
  localparam int JDIV_STEPS = 32;

  // coefficient ratio divider: 49-bit numerator over the zero-thrust ratio
  localparam int CDIV_N_W = 49;
  localparam int CDIV_D_W = 20;

  // stage map, counted in registers after the input stage
  localparam int ST_NUM    = 3;
  localparam int ST_JC     = 38;
  localparam int ST_B      = 77;
  localparam int ST_RHO_A  = 88;
  localparam int ST_RHO_B  = 92;
  localparam int DLY_B     = ST_RHO_B - ST_RHO_A;
  localparam int LAST_STG  = 99;

  localparam logic [1:0] FIFO_DEPTH = 2'd2;

  typedef struct packed {
    logic signed [31:0] shaft_speed;
    logic signed [31:0] airspeed;
    logic [RHO_W-1:0]   air_density;
  } ptt_in_t;

  typedef struct packed {
    logic [31:0]        thrust_out;
    logic [31:0]        torque_out;
    logic signed [31:0] advance_ratio;
  } ptt_out_t;

  // floor(prod / 2^sh), saturated at all ones when it does not fit 64 bits
  function automatic logic [63:0] sat_shr(input logic [127:0] prod, input int unsigned sh);
    logic [127:0] s;
    s = prod >> sh;
    return (s[127:64] != '0) ? '1 : s[63:0];
  endfunction

endpackage

// ===== rtl/core/ptt_mul.sv =====
`timescale 1ns / 1ps
// three-stage 64x64 unsigned multiplier built from 32x32 partial products
module ptt_mul (
  input  logic                         clk,
  input  logic                         en,
  input  logic [ptt_pkg::MUL_W-1:0]    a,
  input  logic [ptt_pkg::MUL_W-1:0]    b,
  output logic [2*ptt_pkg::MUL_W-1:0]  prod
);
  import ptt_pkg::*;

  logic [MUL_W-1:0] pp_ll, pp_lh, pp_hl, pp_hh;
  logic [MUL_W:0]   mid;
  logic [MUL_W-1:0] lo_q, hi_q;

  // partial products, then cross terms, then final sum
  always_ff @(posedge clk) begin
    if (en) begin
      pp_ll <= MUL_W'(a[MUL_HW-1:0]) * MUL_W'(b[MUL_HW-1:0]);
      pp_lh <= MUL_W'(a[MUL_HW-1:0]) * MUL_W'(b[MUL_W-1:MUL_HW]);
      pp_hl <= MUL_W'(a[MUL_W-1:MUL_HW]) * MUL_W'(b[MUL_HW-1:0]);
      pp_hh <= MUL_W'(a[MUL_W-1:MUL_HW]) * MUL_W'(b[MUL_W-1:MUL_HW]);
      mid   <= {1'b0, pp_lh} + {1'b0, pp_hl};
      lo_q  <= pp_ll;
      hi_q  <= pp_hh;
      prod  <= {hi_q, lo_q} + {{(MUL_HW-1){1'b0}}, mid, {MUL_HW{1'b0}}};
    end
  end

endmodule

// ===== rtl/core/ptt_cdiv.sv =====
`timescale 1ns / 1ps
// pipelined restoring divider, one quotient bit per stage, for ratios over j0
module ptt_cdiv (
  input  logic                            clk,
  input  logic                            en,
  input  logic [ptt_pkg::CDIV_N_W-1:0]    num,
  input  logic [ptt_pkg::CDIV_D_W-1:0]    den,
  output logic [ptt_pkg::CDIV_N_W-1:0]    quot
);
  import ptt_pkg::*;

  // den is a configuration value; the user must hold it while items are in flight, the block does not enforce it
  logic [CDIV_D_W-1:0] rem [1:CDIV_N_W];
  logic [CDIV_N_W-1:0] nq  [1:CDIV_N_W];

  for (genvar k = 1; k <= CDIV_N_W; k++) begin : g_step
    logic [CDIV_D_W-1:0] rem_in;
    logic [CDIV_N_W-1:0] nq_in;
    logic [CDIV_D_W:0]   trial;
    logic                fits;

    if (k == 1) begin : g_first
      assign rem_in = '0;
      assign nq_in  = num;
    end else begin : g_rest
      assign rem_in = rem[k-1];
      assign nq_in  = nq[k-1];
    end

    // shift in the next numerator bit, subtract when it fits
    assign trial = {rem_in, nq_in[CDIV_N_W-1]};
    assign fits  = trial >= {1'b0, den};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= fits ? CDIV_D_W'(trial - {1'b0, den}) : trial[CDIV_D_W-1:0];
        nq[k]  <= {nq_in[CDIV_N_W-2:0], fits};
      end
    end
  end

  assign quot = nq[CDIV_N_W];

endmodule

// ===== rtl/core/propeller_thrust_torque.sv =====
`timescale 1ns / 1ps
// propeller thrust and torque pipeline, top level
//
//   channel | handshake             | payload
//   --------+-----------------------+----------------------------------------
//   in      | in_valid / in_ready   | in_data: shaft_speed, airspeed, density
//   out     | out_valid / out_ready | out_data: thrust, torque, advance ratio
//   cfg     | cfg_we                | cfg_index, cfg_data
//
// one item per cycle while the output buffer is not full; a result leaves when out is free
// the pipeline depth is set by the advance ratio divider (32 steps) and the ratio dividers (49)
// rst clears valids, the output buffer and the registers to their defaults
// a two-beat output buffer takes results; the pipeline freezes only when it is full,
// and in_ready comes straight from its fill count
`include "propeller_thrust_torque_defines.svh"
module propeller_thrust_torque (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  ptt_pkg::ptt_in_t                   in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output ptt_pkg::ptt_out_t                  out_data,
  input  logic                               cfg_we,
  input  logic [ptt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ptt_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import ptt_pkg::*;

  // configuration registers
  logic [DIAM_W-1:0] prop_diameter;
  logic [JZ_W-1:0]   zero_thrust_ratio;
  logic [COEF_W-1:0] static_thrust_coeff;
  logic [COEF_W-1:0] profile_torque_coeff;
  logic [JZ_W-1:0]   j0_eff;

  // pipeline control
  logic                en;
  logic [LAST_STG:0]   vld;

  // input stage
  logic [31:0]       s0_w;
  logic [31:0]       s0_v;
  logic [RHO_W-1:0]  s0_rho;
  logic              s0_zero;
  logic [31:0]       vmag;

  // advance ratio path
  logic              neg_line [1:ST_NUM];
  logic [127:0]      num_p, den_p;
  logic [JNUM_W+2:0] jd_n8;
  logic              jd_ovf_in;
  logic [JDEN_W-1:0] jd_rem  [0:JDIV_STEPS];
  logic [31:0]       jd_lq   [0:JDIV_STEPS];
  logic [JDEN_W-1:0] jd_den  [0:JDIV_STEPS];
  logic              jd_ovf  [0:JDIV_STEPS];
  logic              jd_zero [0:JDIV_STEPS];
  logic              jd_neg  [0:JDIV_STEPS];
  logic [31:0]       mag;
  logic [31:0]       j_next;
  logic [31:0]       j_37;
  logic [31:0]       jc, jmag;
  logic [32:0]       a_diff;
  logic [31:0]       jc_38, jmag_38;
  logic [32:0]       a_38;

  // coefficient path
  logic [CDIV_N_W-1:0] q_87, r_87;
  logic [127:0]        qq_p, rr_p, ctp, cqp;
  logic [63:0]         qs_91, rs_91, ct_95, cqr_95, ct_96, cq_96;
  logic [64:0]         cq_sum;

  // speed and diameter path
  logic [30:0]       w_line   [1:ST_B];
  logic [RHO_W-1:0]  rho_line [1:ST_RHO_B];
  logic [127:0]      n24_p, dd_p, n2p, d4p, x4p, d5p, t4p, x5p, t5p;
  logic [63:0]       n2_84, d4_84, x4_88, d5_88, t4_92, x5_92, t5_96;
  logic [63:0]       n2_dly [1:DLY_B];
  logic [63:0]       t4_dly [1:DLY_B];
  logic [127:0]      thr_p, tor_p;
  logic [31:0]       j_line [ST_JC+1:LAST_STG];
  logic              z_line [1:LAST_STG];

  // output buffer
  ptt_out_t          res;
  ptt_out_t          ent [0:1];
  logic              wr_ptr, rd_ptr;
  logic [1:0]        fifo_cnt;
  logic              fifo_push, fifo_pop;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_diameter        <= DIAM_RST;
      zero_thrust_ratio    <= JZ_RST;
      static_thrust_coeff  <= '0;
      profile_torque_coeff <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DIAMETER:       prop_diameter        <= cfg_data[DIAM_W-1:0];
        REG_ZERO_THRUST:    zero_thrust_ratio    <= cfg_data[JZ_W-1:0];
        REG_STATIC_THRUST:  static_thrust_coeff  <= cfg_data[COEF_W-1:0];
        REG_PROFILE_TORQUE: profile_torque_coeff <= cfg_data[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // a zero ratio counts as one lsb
  assign j0_eff = (zero_thrust_ratio == '0) ? JZ_W'(1) : zero_thrust_ratio;

  // global advance: held only while the output buffer is full
  assign en       = (fifo_cnt != FIFO_DEPTH);
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAST_STG-1:0], in_valid};
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (en) begin
      s0_w    <= in_data.shaft_speed;
      s0_v    <= in_data.airspeed;
      s0_rho  <= in_data.air_density;
      s0_zero <= (in_data.shaft_speed == '0) || in_data.shaft_speed[31];
    end
  end

  assign vmag = s0_v[31] ? (~s0_v + 32'd1) : s0_v;

  // numerator |v|*2pi and denominator w*D
  ptt_mul u_mul_num (
    .clk (clk), .en (en),
    .a (MUL_W'(vmag)), .b (MUL_W'(TWO_PI_Q29)), .prod (num_p)
  );
  ptt_mul u_mul_den (
    .clk (clk), .en (en),
    .a (MUL_W'(s0_w[30:0])), .b (MUL_W'(prop_diameter)), .prod (den_p)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      neg_line[1] <= s0_v[31];
      for (int i = 2; i <= ST_NUM; i++) neg_line[i] <= neg_line[i-1];
    end
  end

  // divider setup: quotient of 8*num/den, overflow when it needs more than 32 bits
  assign jd_n8     = {num_p[JNUM_W-1:0], 3'b000};
  assign jd_ovf_in = JDEN_W'(jd_n8[JNUM_W+2:32]) >= den_p[JDEN_W-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      jd_rem[0]  <= jd_ovf_in ? '0 : JDEN_W'(jd_n8[JNUM_W+2:32]);
      jd_lq[0]   <= jd_n8[31:0];
      jd_den[0]  <= den_p[JDEN_W-1:0];
      jd_ovf[0]  <= jd_ovf_in;
      jd_zero[0] <= (num_p[JNUM_W-1:0] == '0);
      jd_neg[0]  <= neg_line[ST_NUM];
    end
  end

  // one quotient bit per stage
  for (genvar k = 1; k <= JDIV_STEPS; k++) begin : g_jdiv
    logic [JDEN_W:0] trial;
    logic            fits;

    assign trial = {jd_rem[k-1], jd_lq[k-1][31]};
    assign fits  = trial >= {1'b0, jd_den[k-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        jd_rem[k]  <= fits ? JDEN_W'(trial - {1'b0, jd_den[k-1]}) : trial[JDEN_W-1:0];
        jd_lq[k]   <= {jd_lq[k-1][30:0], fits};
        jd_den[k]  <= jd_den[k-1];
        jd_ovf[k]  <= jd_ovf[k-1];
        jd_zero[k] <= jd_zero[k-1];
        jd_neg[k]  <= jd_neg[k-1];
      end
    end
  end

  // magnitude capped at 2^31, then signed
  always_comb begin
    if (jd_zero[JDIV_STEPS]) begin
      mag = '0;
    end else if (jd_ovf[JDIV_STEPS] ||
                 (jd_lq[JDIV_STEPS][31] && (jd_lq[JDIV_STEPS][30:0] != '0))) begin
      mag = J_CAP;
    end else begin
      mag = jd_lq[JDIV_STEPS];
    end
    if (jd_neg[JDIV_STEPS]) begin
      j_next = ~mag + 32'd1;
    end else begin
      j_next = mag[31] ? J_POS_MAX : mag;
    end
  end

  always_ff @(posedge clk) begin
    if (en) j_37 <= j_next;
  end

  // clamp at j0, then distance to j0 and magnitude
  always_comb begin
    if ($signed(j_37) > $signed(32'(j0_eff))) begin
      jc = 32'(j0_eff);
    end else begin
      jc = j_37;
    end
    a_diff = 33'(j0_eff) - {jc[31], jc};
    jmag   = jc[31] ? (~jc + 32'd1) : jc;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      jc_38   <= jc;
      a_38    <= a_diff;
      jmag_38 <= jmag;
    end
  end

  // q = (a<<16)/j0 and r = (|J|<<16)/j0
  ptt_cdiv u_cdiv_q (
    .clk (clk), .en (en), .num ({a_38, 16'd0}), .den (j0_eff), .quot (q_87)
  );
  ptt_cdiv u_cdiv_r (
    .clk (clk), .en (en), .num ({1'b0, jmag_38, 16'd0}), .den (j0_eff), .quot (r_87)
  );

  // squares of the ratios
  ptt_mul u_mul_qq (.clk (clk), .en (en), .a (MUL_W'(q_87)), .b (MUL_W'(q_87)), .prod (qq_p));
  ptt_mul u_mul_rr (.clk (clk), .en (en), .a (MUL_W'(r_87)), .b (MUL_W'(r_87)), .prod (rr_p));

  always_ff @(posedge clk) begin
    if (en) begin
      qs_91 <= sat_shr(qq_p, 16);
      rs_91 <= sat_shr(rr_p, 16);
    end
  end

  // scale by ct0
  ptt_mul u_mul_ct (
    .clk (clk), .en (en), .a (MUL_W'(static_thrust_coeff)), .b (qs_91), .prod (ctp)
  );
  ptt_mul u_mul_cq (
    .clk (clk), .en (en), .a (MUL_W'(static_thrust_coeff)), .b (rs_91), .prod (cqp)
  );

  // torque coefficient adds cq0 with saturation
  assign cq_sum = {1'b0, cqr_95} + 65'(profile_torque_coeff);

  always_ff @(posedge clk) begin
    if (en) begin
      ct_95  <= sat_shr(ctp, 16);
      cqr_95 <= sat_shr(cqp, 16);
      ct_96  <= ct_95;
      cq_96  <= cq_sum[64] ? '1 : cq_sum[63:0];
    end
  end

  // speed, density, ratio and the flag for speed not positive follow the item
  always_ff @(posedge clk) begin
    if (en) begin
      w_line[1] <= s0_w[30:0];
      for (int i = 2; i <= ST_B; i++) w_line[i] <= w_line[i-1];
      rho_line[1] <= s0_rho;
      for (int i = 2; i <= ST_RHO_B; i++) rho_line[i] <= rho_line[i-1];
      z_line[1] <= s0_zero;
      for (int i = 2; i <= LAST_STG; i++) z_line[i] <= z_line[i-1];
      j_line[ST_JC+1] <= jc_38;
      for (int i = ST_JC + 2; i <= LAST_STG; i++) j_line[i] <= j_line[i-1];
    end
  end

  // revolutions per second and diameter squared
  ptt_mul u_mul_n24 (
    .clk (clk), .en (en),
    .a (MUL_W'(w_line[ST_B])), .b (MUL_W'(INV_TWO_PI_Q32)), .prod (n24_p)
  );
  ptt_mul u_mul_dd (
    .clk (clk), .en (en),
    .a (MUL_W'(prop_diameter)), .b (MUL_W'(prop_diameter)), .prod (dd_p)
  );

  // n^2 and D^4
  ptt_mul u_mul_n2 (
    .clk (clk), .en (en),
    .a (MUL_W'(n24_p[60:24])), .b (MUL_W'(n24_p[60:24])), .prod (n2p)
  );
  ptt_mul u_mul_d4 (
    .clk (clk), .en (en),
    .a (MUL_W'(dd_p[39:0])), .b (MUL_W'(dd_p[39:0])), .prod (d4p)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      n2_84 <= sat_shr(n2p, 16);
      d4_84 <= sat_shr(d4p, 32);
    end
  end

  // n^2*D^4 and D^5
  ptt_mul u_mul_x4 (.clk (clk), .en (en), .a (n2_84), .b (d4_84), .prod (x4p));
  ptt_mul u_mul_d5 (
    .clk (clk), .en (en), .a (d4_84), .b (MUL_W'(prop_diameter)), .prod (d5p)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      x4_88     <= sat_shr(x4p, 32);
      d5_88     <= sat_shr(d5p, 16);
      n2_dly[1] <= n2_84;
      for (int i = 2; i <= DLY_B; i++) n2_dly[i] <= n2_dly[i-1];
    end
  end

  // thrust scale with density, and n^2*D^5
  ptt_mul u_mul_t4 (
    .clk (clk), .en (en), .a (x4_88), .b (MUL_W'(rho_line[ST_RHO_A])), .prod (t4p)
  );
  ptt_mul u_mul_x5 (.clk (clk), .en (en), .a (n2_dly[DLY_B]), .b (d5_88), .prod (x5p));

  always_ff @(posedge clk) begin
    if (en) begin
      t4_92     <= sat_shr(t4p, 16);
      x5_92     <= sat_shr(x5p, 32);
      t4_dly[1] <= t4_92;
      for (int i = 2; i <= DLY_B; i++) t4_dly[i] <= t4_dly[i-1];
    end
  end

  // torque scale with density
  ptt_mul u_mul_t5 (
    .clk (clk), .en (en), .a (x5_92), .b (MUL_W'(rho_line[ST_RHO_B])), .prod (t5p)
  );

  always_ff @(posedge clk) begin
    if (en) t5_96 <= sat_shr(t5p, 16);
  end

  // coefficient times scale
  ptt_mul u_mul_thr (.clk (clk), .en (en), .a (t4_dly[DLY_B]), .b (ct_96), .prod (thr_p));
  ptt_mul u_mul_tor (.clk (clk), .en (en), .a (t5_96), .b (cq_96), .prod (tor_p));

  // shift by 40, saturate to 32 bits, zero everything for speed not positive
  always_comb begin
    if (z_line[LAST_STG]) begin
      res = '0;
    end else begin
      res.thrust_out    = (thr_p[127:72] != '0) ? '1 : thr_p[71:40];
      res.torque_out    = (tor_p[127:72] != '0) ? '1 : tor_p[71:40];
      res.advance_ratio = j_line[LAST_STG];
    end
  end

  // output buffer, two beats deep
  assign fifo_push = vld[LAST_STG] && en;
  assign fifo_pop  = out_valid && out_ready;
  assign out_valid = (fifo_cnt != 2'd0);
  assign out_data  = ent[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      fifo_cnt <= 2'd0;
      wr_ptr   <= 1'b0;
      rd_ptr   <= 1'b0;
    end else begin
      if (fifo_push) wr_ptr <= ~wr_ptr;
      if (fifo_pop) rd_ptr <= ~rd_ptr;
      if (fifo_push && !fifo_pop) begin
        fifo_cnt <= fifo_cnt + 2'd1;
      end else if (!fifo_push && fifo_pop) begin
        fifo_cnt <= fifo_cnt - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fifo_push) ent[wr_ptr] <= res;
  end

  // checks
  `PTT_ASSERT_NOW(a_fifo_room, fifo_push, fifo_cnt != FIFO_DEPTH, "result buffer overrun")
  `PTT_ASSERT_NOW(a_j_clamp, fifo_push && !z_line[LAST_STG], $signed(res.advance_ratio) <= $signed(32'(j0_eff)), "advance ratio above zero thrust ratio")
  `PTT_ASSERT_NOW(a_no_ct0_thrust, fifo_push && (static_thrust_coeff == '0), res.thrust_out == '0, "thrust without thrust coefficient")
  `PTT_ASSERT_NEXT(a_fill_stall, fifo_push && !fifo_pop && (fifo_cnt == 2'd1), !in_ready, "pipeline moving with full buffer")

endmodule
